### design/ftsp_pkg.sv
package ftsp_pkg;

  localparam int SLOT_COUNT_D    = 4;
  localparam int FRAME_BYTES_D   = 1024;
  localparam int CHUNK_BYTES_D   = 16;
  localparam int RESTORE_BYTES_D = 16;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  typedef enum logic [2:0] {
    FN_BEGIN   = 3'd0,
    FN_FBYTE   = 3'd1,
    FN_RBYTE   = 3'd2,
    FN_COMMIT  = 3'd3,
    FN_ABORT   = 3'd4,
    FN_SEND    = 3'd5
  } func_t;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_INVALID   = 4'd1;
  localparam logic [3:0] ST_BUSY      = 4'd2;
  localparam logic [3:0] ST_STALE     = 4'd3;
  localparam logic [3:0] ST_BADSTATE  = 4'd4;
  localparam logic [3:0] ST_OVERSIZE  = 4'd5;
  localparam logic [3:0] ST_NEEDFULL  = 4'd6;
  localparam logic [3:0] ST_IDLE      = 4'd7;
  localparam logic [3:0] ST_BACKPRESS = 4'd8;
  localparam logic [3:0] ST_OUTFAIL   = 4'd9;

  localparam logic [1:0] SINK_OK    = 2'd0;
  localparam logic [1:0] SINK_BLOCK = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd0;
  localparam logic [1:0] KIND_DELTA = 2'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] generation;
    logic [7:0]  data_byte;
    logic [1:0]  frame_kind;
    logic [1:0]  sink_ans;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        frame_completed;
    logic        no_active;
    logic        redraw_required;
    logic        sink_failed;
    logic [31:0] done_gen;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic decide;     // evaluate the captured word, update bookkeeping
    logic copy;       // move one restore byte into the slot
    logic emit;       // issue one memory read for send
    logic finish;     // marks the final read of a send
  } ftsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic copy_more;   // commit needs restore copy
    logic copy_last;   // current copy is the final one
    logic send_more;   // send has bytes to read
    logic send_last;   // current read is the final one
  } ftsp_sts_t;

  function automatic logic newer(input logic [31:0] cand, input logic [31:0] ref_g);
    logic [31:0] d;
    d = cand - ref_g;
    if (cand == '0) return 1'b0;
    if (ref_g == '0) return 1'b1;
    return (d != '0) && (d < HALF_RANGE);
  endfunction

endpackage

### design/frame_tx_slot_pump_top.sv
// frame transmit slot pump
// one input word is taken at a clock edge with start high and busy low; the
// word carries func, generation, data_byte, frame_kind and the sink answer
// every item answers on the out_ channel: out_valid marks each result word for
// exactly one cycle and the receiver cannot stall, so no buffering is needed
// an ordinary item (begin, byte staging, abort, refused commit or send) gives
// one result, registered in the decide state, and busy drops at the same time
// an accepted commit then copies the restore bytes one by one, as the
// trailer, into the frame slot (up to sixteen), result already given
// an accepted send reads one chunk byte per cycle from the slot memory; the
// byte words appear in the cycle after their reads
// the last byte word carries last; every byte word of a chunk that ends the
// frame carries frame_completed, and all carry the flags after the chunk
// a new item is taken only once the last is through: busy stays high during
// the restore copy loop and the send reads from the single port slot memory
// synchronous active low reset empties all slots and queues and sets redraw;
// the slot memory and restore staging need no clearing
module frame_tx_slot_pump_top
  import ftsp_pkg::*;
#(
  parameter int SLOT_COUNT    = SLOT_COUNT_D,
  parameter int FRAME_BYTES   = FRAME_BYTES_D,
  parameter int CHUNK_BYTES   = CHUNK_BYTES_D,
  parameter int RESTORE_BYTES = RESTORE_BYTES_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  ftsp_cmd_t cmd;
  ftsp_sts_t sts;
  logic      take;
  logic      busy_c;

  assign take = start && !busy_c;
  assign busy = busy_c;

  ftsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy_c),
    .sts   (sts),
    .cmd   (cmd)
  );

  ftsp_dp #(
    .SLOT_COUNT    (SLOT_COUNT),
    .FRAME_BYTES   (FRAME_BYTES),
    .CHUNK_BYTES   (CHUNK_BYTES),
    .RESTORE_BYTES (RESTORE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_w      (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_w     (out_word)
  );

endmodule

### design/ftsp_ctrl.sv
module ftsp_ctrl
  import ftsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ftsp_sts_t  sts,
  output ftsp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_COPY   = 4'b0100,
    S_SEND   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.copy_more)      state_nxt = S_COPY;
        else if (sts.send_more) state_nxt = S_SEND;
        else                    state_nxt = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) state_nxt = S_IDLE;
      end
      S_SEND: begin
        cmd.emit = 1'b1;
        if (sts.send_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/ftsp_dp.sv
module ftsp_dp
  import ftsp_pkg::*;
#(
  parameter int SLOT_COUNT    = SLOT_COUNT_D,
  parameter int FRAME_BYTES   = FRAME_BYTES_D,
  parameter int CHUNK_BYTES   = CHUNK_BYTES_D,
  parameter int RESTORE_BYTES = RESTORE_BYTES_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  in_word_t  in_w,
  input  ftsp_cmd_t cmd,
  output ftsp_sts_t sts,
  output logic      out_valid,
  output out_word_t out_w
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int MW = SW + AW;
  localparam int RW = $clog2(RESTORE_BYTES + 1);
  localparam int RI = (RESTORE_BYTES > 1) ? $clog2(RESTORE_BYTES) : 1;
  localparam int CW = $clog2(CHUNK_BYTES + 1);

  // slot stores
  logic [7:0]    mem [SLOT_COUNT << AW];
  logic [7:0]    rst_store [RESTORE_BYTES];
  logic [LW-1:0] len_r  [SLOT_COUNT];
  logic [31:0]   gen_r  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] full_r;

  logic          act_v_r, pend_v_r, stg_v_r;
  logic [SW-1:0] act_r, pend_r, stg_r;
  logic [LW-1:0] off_r;
  logic [31:0]   last_acc_r, last_cmp_r;
  logic          stg_over_r, redraw_r, failed_r;
  logic [RW-1:0] rcnt_r;
  logic          rovf_r;

  in_word_t      w_r;
  // commit copy bookkeeping
  logic [SW-1:0] cp_slot_r;
  logic [LW-1:0] cp_base_r;
  logic [RW-1:0] cp_idx_r, cp_len_r;
  // send bookkeeping
  logic [CW-1:0] sd_idx_r, sd_len_r;
  logic [MW-1:0] sd_addr_r;
  logic          sd_done_r;
  logic [3:0]    st_r;
  // read pipeline
  logic          rd_v_r, rd_last_r;
  logic [7:0]    rd_q_r;
  logic          one_v_r;
  logic          go_send_r;

  // decision made in the decide cycle, combinational
  logic [SW-1:0] free_s;
  logic          free_ok;
  logic [LW-1:0] rem, chunk_l, noff;
  logic          ends_frame;

  always_comb begin
    free_ok = 1'b0;
    free_s  = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!(act_v_r && act_r == SW'(s)) && !(pend_v_r && pend_r == SW'(s)) &&
          !(stg_v_r && stg_r == SW'(s))) begin
        free_ok = 1'b1;
        free_s  = SW'(s);
      end
    end
  end

  assign rem        = len_r[act_r] - off_r;
  assign chunk_l    = (rem > LW'(CHUNK_BYTES)) ? LW'(CHUNK_BYTES) : rem;
  assign noff       = off_r + chunk_l;
  assign ends_frame = (noff == len_r[act_r]);

  logic [LW-1:0] slen;
  assign slen = len_r[stg_r];

  always_ff @(posedge clk) begin
    if (take) w_r <= in_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        len_r[s] <= '0;
        gen_r[s] <= '0;
      end
      full_r     <= '0;
      act_v_r    <= 1'b0;
      pend_v_r   <= 1'b0;
      stg_v_r    <= 1'b0;
      act_r      <= '0;
      pend_r     <= '0;
      stg_r      <= '0;
      off_r      <= '0;
      last_acc_r <= '0;
      last_cmp_r <= '0;
      stg_over_r <= 1'b0;
      redraw_r   <= 1'b1;
      failed_r   <= 1'b0;
      rcnt_r     <= '0;
      rovf_r     <= 1'b0;
      one_v_r    <= 1'b0;
      rd_v_r     <= 1'b0;
      go_send_r  <= 1'b0;
    end else begin
      one_v_r <= 1'b0;
      rd_v_r  <= cmd.emit;
      if (cmd.decide) begin
        automatic logic [3:0] st = ST_INVALID;
        automatic logic abandon = 1'b0, drop = 1'b0, fail = 1'b0;
        automatic logic gs = 1'b0;
        unique case (w_r.func)
          FN_BEGIN: begin
            if (w_r.generation == '0) st = ST_INVALID;
            else if (stg_v_r) st = ST_BUSY;
            else if (!newer(w_r.generation, last_acc_r)) st = ST_STALE;
            else if (!free_ok) st = ST_BUSY;
            else begin
              st = ST_OK;
              len_r[free_s]  <= '0;
              gen_r[free_s]  <= w_r.generation;
              full_r[free_s] <= 1'b0;
              stg_r          <= free_s;
              stg_v_r        <= 1'b1;
              stg_over_r     <= 1'b0;
            end
          end
          FN_FBYTE: begin
            if (!stg_v_r) st = ST_BADSTATE;
            else if (stg_over_r) st = ST_OVERSIZE;
            else if (slen >= LW'(FRAME_BYTES)) begin
              st = ST_OVERSIZE;
              stg_over_r <= 1'b1;
            end else begin
              st = ST_OK;
              len_r[stg_r] <= slen + 1'b1;
            end
          end
          FN_RBYTE: begin
            if (rcnt_r < RW'(RESTORE_BYTES)) begin
              st = ST_OK;
              rcnt_r <= rcnt_r + 1'b1;
            end else begin
              st = ST_OVERSIZE;
              rovf_r <= 1'b1;
            end
          end
          FN_COMMIT: begin
            rcnt_r <= '0;
            rovf_r <= 1'b0;
            if (!stg_v_r) st = ST_BADSTATE;
            else if (stg_over_r) begin st = ST_OVERSIZE; abandon = 1'b1; end
            else if (w_r.frame_kind > KIND_DELTA || (rcnt_r == '0 && !rovf_r) ||
                     slen == '0) begin
              st = ST_INVALID; abandon = 1'b1;
            end
            else if (rovf_r) begin st = ST_OVERSIZE; abandon = 1'b1; end
            else if ((LW+1)'(rcnt_r) > (LW+1)'(FRAME_BYTES) - (LW+1)'(slen)) begin
              st = ST_OVERSIZE; abandon = 1'b1;
            end
            else if (!newer(gen_r[stg_r], last_acc_r)) begin
              st = ST_STALE; abandon = 1'b1;
            end
            else if (w_r.frame_kind == KIND_DELTA && redraw_r) begin
              st = ST_NEEDFULL; drop = 1'b1;
            end
            else if (act_v_r && pend_v_r && w_r.frame_kind == KIND_DELTA) begin
              st = ST_NEEDFULL; drop = 1'b1;
              pend_v_r <= 1'b0;
              len_r[pend_r]  <= '0;
              gen_r[pend_r]  <= '0;
              full_r[pend_r] <= 1'b0;
              redraw_r <= 1'b1;
            end else begin
              st = ST_OK;
              cp_slot_r <= stg_r;
              cp_base_r <= slen;
              cp_idx_r  <= '0;
              cp_len_r  <= rcnt_r;
              len_r[stg_r]  <= slen + LW'(rcnt_r);
              full_r[stg_r] <= (w_r.frame_kind == KIND_FULL);
              if (!act_v_r) begin
                act_v_r <= 1'b1;
                act_r   <= stg_r;
                off_r   <= '0;
              end else if (!pend_v_r) begin
                pend_v_r <= 1'b1;
                pend_r   <= stg_r;
              end else begin
                pend_r <= stg_r;
                len_r[pend_r]  <= '0;
                gen_r[pend_r]  <= '0;
                full_r[pend_r] <= 1'b0;
              end
              stg_v_r    <= 1'b0;
              stg_over_r <= 1'b0;
              last_acc_r <= gen_r[stg_r];
              if (w_r.frame_kind == KIND_FULL) redraw_r <= 1'b0;
            end
          end
          FN_ABORT: begin
            st = ST_OK;
            abandon = 1'b1;
            rcnt_r <= '0;
            rovf_r <= 1'b0;
          end
          FN_SEND: begin
            if (!act_v_r) st = ST_IDLE;
            else if (off_r >= len_r[act_r]) begin st = ST_OUTFAIL; fail = 1'b1; end
            else if (w_r.sink_ans == SINK_BLOCK) st = ST_BACKPRESS;
            else if (w_r.sink_ans != SINK_OK) begin st = ST_OUTFAIL; fail = 1'b1; end
            else begin
              st = ST_OK;
              gs = 1'b1;
              sd_idx_r  <= '0;
              sd_len_r  <= CW'(chunk_l);
              sd_addr_r <= {act_r, AW'(off_r)};
              // flags on every byte word show the state after the chunk
              sd_done_r <= ends_frame;
              if (ends_frame) begin
                last_cmp_r <= gen_r[act_r];
                act_v_r    <= pend_v_r;
                act_r      <= pend_r;
                pend_v_r   <= 1'b0;
                off_r      <= '0;
                len_r[act_r] <= '0; gen_r[act_r] <= '0; full_r[act_r] <= 1'b0;
                if (full_r[act_r]) failed_r <= 1'b0;
              end else begin
                off_r <= noff;
              end
            end
          end
          default: st = ST_INVALID;
        endcase
        if (fail) begin
          act_v_r  <= 1'b0;
          pend_v_r <= 1'b0;
          off_r    <= '0;
          if (act_v_r) begin
            len_r[act_r] <= '0; gen_r[act_r] <= '0; full_r[act_r] <= 1'b0;
          end
          if (pend_v_r) begin
            len_r[pend_r] <= '0; gen_r[pend_r] <= '0; full_r[pend_r] <= 1'b0;
          end
          abandon  = 1'b1;
          failed_r <= 1'b1;
        end
        if ((abandon || drop) && stg_v_r) begin
          if (abandon && !fail && (slen != '0 || stg_over_r)) redraw_r <= 1'b1;
          len_r[stg_r] <= '0; gen_r[stg_r] <= '0; full_r[stg_r] <= 1'b0;
        end
        if (abandon || drop) begin
          stg_v_r    <= 1'b0;
          stg_over_r <= 1'b0;
        end
        if (fail) redraw_r <= 1'b1;
        st_r      <= st;
        go_send_r <= gs;
        one_v_r   <= 1'b1;
      end
      if (cmd.copy) cp_idx_r <= cp_idx_r + 1'b1;
      if (cmd.emit) begin
        sd_idx_r  <= sd_idx_r + 1'b1;
        sd_addr_r <= sd_addr_r + 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.decide && w_r.func == FN_FBYTE && stg_v_r && !stg_over_r &&
        slen < LW'(FRAME_BYTES))
      mem[{stg_r, AW'(slen)}] <= w_r.data_byte;
    else if (cmd.copy)
      mem[{cp_slot_r, AW'(cp_base_r + LW'(cp_idx_r))}] <= rst_store[RI'(cp_idx_r)];
    if (cmd.emit) rd_q_r <= mem[sd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && w_r.func == FN_RBYTE && rcnt_r < RW'(RESTORE_BYTES))
      rst_store[RI'(rcnt_r)] <= w_r.data_byte;
  end

  always_ff @(posedge clk) begin
    rd_last_r <= cmd.finish;
  end

  // status to controller; copy_more and send_more are valid in the decide cycle:
  // decide uses combinational predictions of its own outcome
  logic pred_copy, pred_send;
  assign pred_copy = (w_r.func == FN_COMMIT) && stg_v_r && !stg_over_r &&
                     w_r.frame_kind <= KIND_DELTA && rcnt_r != '0 && !rovf_r &&
                     slen != '0 &&
                     (LW+1)'(rcnt_r) <= (LW+1)'(FRAME_BYTES) - (LW+1)'(slen) &&
                     newer(gen_r[stg_r], last_acc_r) &&
                     !(w_r.frame_kind == KIND_DELTA && redraw_r) &&
                     !(act_v_r && pend_v_r && w_r.frame_kind == KIND_DELTA);
  assign pred_send = (w_r.func == FN_SEND) && act_v_r && off_r < len_r[act_r] &&
                     w_r.sink_ans == SINK_OK;

  assign sts.copy_more = pred_copy;
  assign sts.copy_last = (cp_idx_r + 1'b1 == cp_len_r);
  assign sts.send_more = pred_send;
  assign sts.send_last = (sd_idx_r + 1'b1 == sd_len_r);

  // result: single result after decide unless a send is accepted; bytes in the cycle after each read
  assign out_valid = (one_v_r && !go_send_r) || rd_v_r;

  always_comb begin
    out_w = '0;
    out_w.no_active       = !act_v_r;
    out_w.redraw_required = redraw_r;
    out_w.sink_failed     = failed_r;
    out_w.done_gen        = last_cmp_r;
    if (rd_v_r) begin
      out_w.status     = ST_OK;
      out_w.out_byte   = rd_q_r;
      out_w.byte_valid = 1'b1;
      out_w.last       = rd_last_r;
      out_w.frame_completed = sd_done_r;
    end else begin
      out_w.status = st_r;
      out_w.last   = 1'b1;
    end
  end

endmodule
